// File: hdl/affine_matrix_composer_macros.svh
// Assertion helpers for the checker file.
`ifndef AFFINE_MATRIX_COMPOSER_MACROS_SVH
`define AFFINE_MATRIX_COMPOSER_MACROS_SVH

// Next-cycle implication, ignored while reset is asserted.
`define AMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("amc: next-cycle check failed");

// Next-cycle implication that also holds through reset.
`define AMC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("amc: reset check failed");

`endif

// File: hdl/amc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amc_pkg
// Shared constants, datapath micro-op codes and term tables.
// ----------------------------------------------------------------------------
package amc_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // commands
    localparam logic [2:0] CMD_IDENT  = 3'd0;
    localparam logic [2:0] CMD_SKEW   = 3'd1;
    localparam logic [2:0] CMD_SCALE  = 3'd2;
    localparam logic [2:0] CMD_TRANS  = 3'd3;
    localparam logic [2:0] CMD_ROTATE = 3'd4;
    localparam logic [2:0] CMD_MULT   = 3'd5;

    // matrix entries
    localparam logic [2:0] E_A  = 3'd0;
    localparam logic [2:0] E_B  = 3'd1;
    localparam logic [2:0] E_TX = 3'd2;
    localparam logic [2:0] E_C  = 3'd3;
    localparam logic [2:0] E_D  = 3'd4;
    localparam logic [2:0] E_TY = 3'd5;

    // second multiplier operand
    localparam logic [3:0] OB_VX   = 4'd0;
    localparam logic [3:0] OB_VY   = 4'd1;
    localparam logic [3:0] OB_TANX = 4'd2;
    localparam logic [3:0] OB_TANY = 4'd3;
    localparam logic [3:0] OB_COS  = 4'd4;
    localparam logic [3:0] OB_SIN  = 4'd5;
    localparam logic [3:0] OB_OA   = 4'd6;
    localparam logic [3:0] OB_OB   = 4'd7;
    localparam logic [3:0] OB_OTX  = 4'd8;
    localparam logic [3:0] OB_OC   = 4'd9;
    localparam logic [3:0] OB_OD   = 4'd10;
    localparam logic [3:0] OB_OTY  = 4'd11;

    // datapath micro-ops
    localparam logic [3:0] OP_NOP    = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_CORD   = 4'd2;
    localparam logic [3:0] OP_DIV    = 4'd3;
    localparam logic [3:0] OP_TAN    = 4'd4;
    localparam logic [3:0] OP_BASE   = 4'd5;
    localparam logic [3:0] OP_MUL    = 4'd6;
    localparam logic [3:0] OP_ADD    = 4'd7;
    localparam logic [3:0] OP_STAGE  = 4'd8;
    localparam logic [3:0] OP_IDENT  = 4'd9;
    localparam logic [3:0] OP_COMMIT = 4'd10;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] idx;       // entry, or angle select for CORD/TAN
        logic [3:0] mul_b;
        logic       base_zero;
        logic       sh30;
        logic       sub;
    } dp_cmd_t;

    typedef struct packed {
        logic cord_busy;
        logic div_busy;
    } dp_status_t;

    typedef struct packed {
        logic [1:0] nterms;
        logic       base_zero;
        logic [2:0] a0;
        logic [3:0] b0;
        logic [2:0] a1;
        logic [3:0] b1;
        logic       sh30;
        logic       sub1;
    } term_t;

    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    // Terms that make up one new entry for a command.
    function automatic term_t amc_term(input logic [2:0] cmd, input logic [2:0] entry);
        term_t t;
        logic [2:0] lo;
        logic [2:0] hi;
        logic col0;
        logic col1;
        logic col2;
        lo   = (entry < E_C) ? E_A : E_C;
        hi   = (entry < E_C) ? E_B : E_D;
        col0 = (entry == E_A)  || (entry == E_C);
        col1 = (entry == E_B)  || (entry == E_D);
        col2 = (entry == E_TX) || (entry == E_TY);
        t    = '0;
        unique case (cmd)
            CMD_SKEW: begin
                if (col0) begin
                    t.nterms = 2'd1; t.a0 = hi; t.b0 = OB_TANY;
                end else if (col1) begin
                    t.nterms = 2'd1; t.a0 = lo; t.b0 = OB_TANX;
                end
            end
            CMD_SCALE: begin
                if (col0) begin
                    t.base_zero = 1'b1; t.nterms = 2'd1; t.a0 = lo; t.b0 = OB_VX;
                end else if (col1) begin
                    t.base_zero = 1'b1; t.nterms = 2'd1; t.a0 = hi; t.b0 = OB_VY;
                end
            end
            CMD_TRANS: begin
                if (col2) begin
                    t.nterms = 2'd2;
                    t.a0 = lo; t.b0 = OB_VX; t.a1 = hi; t.b1 = OB_VY;
                end
            end
            CMD_ROTATE: begin
                t.sh30 = 1'b1;
                if (col0) begin
                    t.base_zero = 1'b1; t.nterms = 2'd2;
                    t.a0 = lo; t.b0 = OB_COS; t.a1 = hi; t.b1 = OB_SIN;
                end else if (col1) begin
                    t.base_zero = 1'b1; t.nterms = 2'd2; t.sub1 = 1'b1;
                    t.a0 = hi; t.b0 = OB_COS; t.a1 = lo; t.b1 = OB_SIN;
                end
            end
            CMD_MULT: begin
                t.nterms = 2'd2;
                t.a0 = lo;
                t.a1 = hi;
                if (col0) begin
                    t.base_zero = 1'b1; t.b0 = OB_OA; t.b1 = OB_OC;
                end else if (col1) begin
                    t.base_zero = 1'b1; t.b0 = OB_OB; t.b1 = OB_OD;
                end else begin
                    t.b0 = OB_OTX; t.b1 = OB_OTY;
                end
            end
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

// File: hdl/amc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amc_datapath
// Matrix store, CORDIC, tangent divider, shared multiplier and accumulator.
// ----------------------------------------------------------------------------
module amc_datapath
    import amc_pkg::*;
#(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  dp_cmd_t            dp_cmd,
    output dp_status_t         dp_status,
    input  logic signed [31:0] s_value_x,
    input  logic signed [31:0] s_value_y,
    input  logic        [15:0] s_angle_x,
    input  logic        [15:0] s_angle_y,
    input  logic signed [31:0] s_other_a,
    input  logic signed [31:0] s_other_b,
    input  logic signed [31:0] s_other_tx,
    input  logic signed [31:0] s_other_c,
    input  logic signed [31:0] s_other_d,
    input  logic signed [31:0] s_other_ty,
    output logic signed [31:0] m_out_a,
    output logic signed [31:0] m_out_b,
    output logic signed [31:0] m_out_tx,
    output logic signed [31:0] m_out_c,
    output logic signed [31:0] m_out_d,
    output logic signed [31:0] m_out_ty,
    output logic               m_saturated
);

    localparam int CIW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int DVW = 33 + FRAC_BITS;          // dividend / quotient width
    localparam int DCW = $clog2(DVW + 1);
    localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] HALF_F = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [63:0] HALF_30 = 64'sd1 <<< 29;

    // matrix and staging
    logic signed [31:0] mat_reg  [6];
    logic signed [31:0] nmat_reg [6];
    logic               flag_reg;

    // latched operands
    logic signed [31:0] vx_reg, vy_reg;
    logic        [15:0] angx_reg, angy_reg;
    logic signed [31:0] oa_reg, ob_reg, otx_reg, oc_reg, od_reg, oty_reg;
    logic signed [31:0] tanx_reg, tany_reg;

    // CORDIC
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic     [CIW-1:0] citer_reg;
    logic               cflip_reg;
    logic               cbusy_reg;
    logic signed [31:0] cos_w, sin_w;

    // divider
    logic     [DVW-1:0] dvd_reg;
    logic        [32:0] rem_reg;
    logic        [31:0] dsor_reg;
    logic     [DCW-1:0] dcnt_reg;
    logic               dbusy_reg;
    logic               dneg_reg, czero_reg, spos_reg;

    // multiply / accumulate
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic signed [31:0] opa_w, opb_w;
    logic signed [63:0] rnd_w;

    assign dp_status.cord_busy = cbusy_reg;
    assign dp_status.div_busy  = dbusy_reg;

    assign cos_w = cflip_reg ? -cx_reg[31:0] : cx_reg[31:0];
    assign sin_w = cflip_reg ? -cy_reg[31:0] : cy_reg[31:0];

    assign opa_w = mat_reg[dp_cmd.idx];

    always_comb begin
        unique case (dp_cmd.mul_b)
            OB_VX:   opb_w = vx_reg;
            OB_VY:   opb_w = vy_reg;
            OB_TANX: opb_w = tanx_reg;
            OB_TANY: opb_w = tany_reg;
            OB_COS:  opb_w = cos_w;
            OB_SIN:  opb_w = sin_w;
            OB_OA:   opb_w = oa_reg;
            OB_OB:   opb_w = ob_reg;
            OB_OTX:  opb_w = otx_reg;
            OB_OC:   opb_w = oc_reg;
            OB_OD:   opb_w = od_reg;
            OB_OTY:  opb_w = oty_reg;
            default: opb_w = '0;
        endcase
    end

    assign rnd_w = dp_cmd.sh30 ? ((prod_reg + HALF_30) >>> 30)
                               : ((prod_reg + HALF_F) >>> FRAC_BITS);

    // CORDIC start and step
    logic        [15:0] cang_w, cfold_w;
    logic               cfl_w;
    logic signed [33:0] cdx_w, cdy_w, catan_w;

    assign cang_w  = dp_cmd.idx[0] ? angy_reg : angx_reg;
    assign cfl_w   = (cang_w >= 16'h4000) && (cang_w < 16'hC000);
    assign cfold_w = cfl_w ? (cang_w + 16'h8000) : cang_w;
    assign cdx_w   = cy_reg >>> citer_reg;
    assign cdy_w   = cx_reg >>> citer_reg;
    assign catan_w = $signed({2'b00, atan_lut(5'(citer_reg))});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cbusy_reg <= 1'b0;
        end else if (dp_cmd.op == OP_CORD) begin
            cbusy_reg <= 1'b1;
            cx_reg    <= CORDIC_GAIN;
            cy_reg    <= '0;
            cz_reg    <= 34'($signed({cfold_w, 16'h0000}));
            citer_reg <= '0;
            cflip_reg <= cfl_w;
        end else if (cbusy_reg) begin
            if (!cz_reg[33]) begin
                cx_reg <= cx_reg - cdx_w;
                cy_reg <= cy_reg + cdy_w;
                cz_reg <= cz_reg - catan_w;
            end else begin
                cx_reg <= cx_reg + cdx_w;
                cy_reg <= cy_reg - cdy_w;
                cz_reg <= cz_reg + catan_w;
            end
            citer_reg <= citer_reg + 1'b1;
            if (citer_reg == CIW'(CORDIC_STEPS - 1)) begin
                cbusy_reg <= 1'b0;
            end
        end
    end

    // restoring divider for the tangent: round(|s| << F / |c|)
    logic [31:0] sabs_w, cabs_w;
    logic [32:0] rsh_w;
    logic        qbit_w;

    assign sabs_w = sin_w[31] ? (~sin_w + 32'd1) : sin_w;
    assign cabs_w = cos_w[31] ? (~cos_w + 32'd1) : cos_w;
    assign rsh_w  = {rem_reg[31:0], dvd_reg[DVW-1]};
    assign qbit_w = (rsh_w >= {1'b0, dsor_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbusy_reg <= 1'b0;
        end else if (dp_cmd.op == OP_DIV) begin
            dbusy_reg <= 1'b1;
            dvd_reg   <= (DVW'(sabs_w) << FRAC_BITS) + DVW'(cabs_w >> 1);
            rem_reg   <= '0;
            dsor_reg  <= cabs_w;
            dcnt_reg  <= '0;
            dneg_reg  <= sin_w[31] != cos_w[31];
            czero_reg <= (cos_w == 32'sd0);
            spos_reg  <= !sin_w[31];
        end else if (dbusy_reg) begin
            rem_reg  <= qbit_w ? (rsh_w - {1'b0, dsor_reg}) : rsh_w;
            dvd_reg  <= {dvd_reg[DVW-2:0], qbit_w};
            dcnt_reg <= dcnt_reg + 1'b1;
            if (dcnt_reg == DCW'(DVW - 1)) begin
                dbusy_reg <= 1'b0;
            end
        end
    end

    // tangent clip
    logic signed [31:0] tan_w;
    logic               tsat_w;

    always_comb begin
        tsat_w = 1'b1;
        if (czero_reg) begin
            tan_w = spos_reg ? 32'sh7FFFFFFF : 32'sh80000000;
        end else if (!dneg_reg && (dvd_reg > DVW'(32'h7FFFFFFF))) begin
            tan_w = 32'sh7FFFFFFF;
        end else if (dneg_reg && (dvd_reg > DVW'(33'h080000000))) begin
            tan_w = 32'sh80000000;
        end else begin
            tsat_w = 1'b0;
            tan_w  = dneg_reg ? (~dvd_reg[31:0] + 32'd1) : dvd_reg[31:0];
        end
    end

    // entry clip
    logic               esat_w;
    logic signed [31:0] esat_val_w;

    always_comb begin
        esat_w     = !((&acc_reg[63:31]) || !(|acc_reg[63:31]));
        esat_val_w = esat_w ? (acc_reg[63] ? 32'sh80000000 : 32'sh7FFFFFFF)
                            : acc_reg[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mat_reg[E_A]  <= ONE_Q;
            mat_reg[E_B]  <= '0;
            mat_reg[E_TX] <= '0;
            mat_reg[E_C]  <= '0;
            mat_reg[E_D]  <= ONE_Q;
            mat_reg[E_TY] <= '0;
            flag_reg      <= 1'b0;
        end else begin
            unique case (dp_cmd.op)
                OP_LOAD: begin
                    vx_reg   <= s_value_x;
                    vy_reg   <= s_value_y;
                    angx_reg <= s_angle_x;
                    angy_reg <= s_angle_y;
                    oa_reg   <= s_other_a;
                    ob_reg   <= s_other_b;
                    otx_reg  <= s_other_tx;
                    oc_reg   <= s_other_c;
                    od_reg   <= s_other_d;
                    oty_reg  <= s_other_ty;
                    nmat_reg <= mat_reg;
                    flag_reg <= 1'b0;
                end
                OP_TAN: begin
                    if (dp_cmd.idx[0]) begin
                        tany_reg <= tan_w;
                    end else begin
                        tanx_reg <= tan_w;
                    end
                    flag_reg <= flag_reg | tsat_w;
                end
                OP_BASE: begin
                    acc_reg <= dp_cmd.base_zero ? 64'sd0 : 64'(opa_w);
                end
                OP_MUL: begin
                    prod_reg <= opa_w * opb_w;
                end
                OP_ADD: begin
                    acc_reg <= dp_cmd.sub ? (acc_reg - rnd_w) : (acc_reg + rnd_w);
                end
                OP_STAGE: begin
                    nmat_reg[dp_cmd.idx] <= esat_val_w;
                    flag_reg             <= flag_reg | esat_w;
                end
                OP_IDENT: begin
                    nmat_reg[E_A]  <= ONE_Q;
                    nmat_reg[E_B]  <= '0;
                    nmat_reg[E_TX] <= '0;
                    nmat_reg[E_C]  <= '0;
                    nmat_reg[E_D]  <= ONE_Q;
                    nmat_reg[E_TY] <= '0;
                end
                OP_COMMIT: begin
                    mat_reg     <= nmat_reg;
                    m_out_a     <= nmat_reg[E_A];
                    m_out_b     <= nmat_reg[E_B];
                    m_out_tx    <= nmat_reg[E_TX];
                    m_out_c     <= nmat_reg[E_C];
                    m_out_d     <= nmat_reg[E_D];
                    m_out_ty    <= nmat_reg[E_TY];
                    m_saturated <= flag_reg;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: hdl/amc_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amc_controller
// Command sequencer: issues datapath micro-ops, owns both handshakes.
// ----------------------------------------------------------------------------
module amc_controller
    import amc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_cmd,
    output logic       m_valid,
    input  logic       m_ready,
    output dp_cmd_t    dp_cmd,
    input  dp_status_t dp_status
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CORD   = 4'd1;
    localparam logic [3:0] ST_CWAIT  = 4'd2;
    localparam logic [3:0] ST_DIV    = 4'd3;
    localparam logic [3:0] ST_DWAIT  = 4'd4;
    localparam logic [3:0] ST_TAN    = 4'd5;
    localparam logic [3:0] ST_BASE   = 4'd6;
    localparam logic [3:0] ST_MUL    = 4'd7;
    localparam logic [3:0] ST_ADD    = 4'd8;
    localparam logic [3:0] ST_STAGE  = 4'd9;
    localparam logic [3:0] ST_IDENT  = 4'd10;
    localparam logic [3:0] ST_COMMIT = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [2:0] cmd_reg, cmd_next;
    logic [2:0] entry_reg, entry_next;
    logic       asel_reg, asel_next;
    logic       term_reg, term_next;
    logic       mvalid_reg, mvalid_next;
    term_t      term_w;

    assign term_w  = amc_term(cmd_reg, entry_reg);
    assign m_valid = mvalid_reg;

    always_comb begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        entry_next  = entry_reg;
        asel_next   = asel_reg;
        term_next   = term_reg;
        mvalid_next = mvalid_reg && !m_ready;
        s_ready     = 1'b0;
        dp_cmd      = '0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    dp_cmd.op  = OP_LOAD;
                    cmd_next   = s_cmd;
                    entry_next = E_A;
                    asel_next  = 1'b0;
                    unique case (s_cmd)
                        CMD_IDENT:                      state_next = ST_IDENT;
                        CMD_SKEW, CMD_ROTATE:           state_next = ST_CORD;
                        CMD_SCALE, CMD_TRANS, CMD_MULT: state_next = ST_BASE;
                        default:                        state_next = ST_COMMIT;
                    endcase
                end
            end
            ST_CORD: begin
                dp_cmd.op  = OP_CORD;
                dp_cmd.idx = {2'b00, asel_reg};
                state_next = ST_CWAIT;
            end
            ST_CWAIT: begin
                if (!dp_status.cord_busy) begin
                    state_next = (cmd_reg == CMD_ROTATE) ? ST_BASE : ST_DIV;
                end
            end
            ST_DIV: begin
                dp_cmd.op  = OP_DIV;
                state_next = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (!dp_status.div_busy) begin
                    state_next = ST_TAN;
                end
            end
            ST_TAN: begin
                dp_cmd.op  = OP_TAN;
                dp_cmd.idx = {2'b00, asel_reg};
                if (!asel_reg) begin
                    asel_next  = 1'b1;
                    state_next = ST_CORD;
                end else begin
                    state_next = ST_BASE;
                end
            end
            ST_BASE: begin
                dp_cmd.op        = OP_BASE;
                dp_cmd.idx       = entry_reg;
                dp_cmd.base_zero = term_w.base_zero;
                term_next        = 1'b0;
                state_next       = (term_w.nterms == 2'd0) ? ST_STAGE : ST_MUL;
            end
            ST_MUL: begin
                dp_cmd.op    = OP_MUL;
                dp_cmd.idx   = term_reg ? term_w.a1 : term_w.a0;
                dp_cmd.mul_b = term_reg ? term_w.b1 : term_w.b0;
                state_next   = ST_ADD;
            end
            ST_ADD: begin
                dp_cmd.op   = OP_ADD;
                dp_cmd.sh30 = term_w.sh30;
                dp_cmd.sub  = term_reg & term_w.sub1;
                if (!term_reg && (term_w.nterms == 2'd2)) begin
                    term_next  = 1'b1;
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_STAGE;
                end
            end
            ST_STAGE: begin
                dp_cmd.op  = OP_STAGE;
                dp_cmd.idx = entry_reg;
                if (entry_reg == E_TY) begin
                    state_next = ST_COMMIT;
                end else begin
                    entry_next = entry_reg + 3'd1;
                    state_next = ST_BASE;
                end
            end
            ST_IDENT: begin
                dp_cmd.op  = OP_IDENT;
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                // hold until the previous result beat is gone
                if (!mvalid_reg || m_ready) begin
                    dp_cmd.op   = OP_COMMIT;
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
            cmd_reg    <= CMD_IDENT;
            entry_reg  <= E_A;
            asel_reg   <= 1'b0;
            term_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
            cmd_reg    <= cmd_next;
            entry_reg  <= entry_next;
            asel_reg   <= asel_next;
            term_reg   <= term_next;
        end
    end

endmodule

// File: hdl/affine_matrix_composer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_matrix_composer
// 2x3 affine matrix composer with CORDIC trig and tangent divider.
// ----------------------------------------------------------------------------
// Holds a 2x3 Q(32-FRAC_BITS).FRAC_BITS matrix (a b tx ; c d ty), reset to
// identity, and post-multiplies it by one command per input beat: identity,
// skew, scale, translate, rotate or multiply. Each command returns one beat
// with all six entries and a saturation flag. One item is in flight at a
// time; the result sits in an output register, so the next beat can be
// accepted while it waits. Except for identity and unused codes, the
// sequencer walks every entry through one shared 32x32 multiplier (base
// load, a multiply and an add per product, one store) plus the bit-serial
// trig units: rotate runs one CORDIC pass, and skew runs two CORDIC passes
// and two restoring divisions of 33 + FRAC_BITS steps each. m_valid rises
// at the commit edge. The commit cycle stretches for as long as an earlier
// result beat is still waiting for m_ready. Unused command codes return
// the current matrix with saturated clear.
// ----------------------------------------------------------------------------
module affine_matrix_composer
    import amc_pkg::*;
#(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // command beat
    input  logic               s_valid,
    output logic               s_ready,
    input  logic        [2:0]  s_cmd,
    input  logic signed [31:0] s_value_x,
    input  logic signed [31:0] s_value_y,
    input  logic        [15:0] s_angle_x,
    input  logic        [15:0] s_angle_y,
    input  logic signed [31:0] s_other_a,
    input  logic signed [31:0] s_other_b,
    input  logic signed [31:0] s_other_tx,
    input  logic signed [31:0] s_other_c,
    input  logic signed [31:0] s_other_d,
    input  logic signed [31:0] s_other_ty,
    // result beat
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_out_a,
    output logic signed [31:0] m_out_b,
    output logic signed [31:0] m_out_tx,
    output logic signed [31:0] m_out_c,
    output logic signed [31:0] m_out_d,
    output logic signed [31:0] m_out_ty,
    output logic               m_saturated
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // sequencer: decodes the command, steps through entries and terms
    amc_controller u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_cmd     (s_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status)
    );

    // matrix store, trig, divider, multiplier and output register
    amc_datapath #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .dp_cmd      (dp_cmd),
        .dp_status   (dp_status),
        .s_value_x   (s_value_x),
        .s_value_y   (s_value_y),
        .s_angle_x   (s_angle_x),
        .s_angle_y   (s_angle_y),
        .s_other_a   (s_other_a),
        .s_other_b   (s_other_b),
        .s_other_tx  (s_other_tx),
        .s_other_c   (s_other_c),
        .s_other_d   (s_other_d),
        .s_other_ty  (s_other_ty),
        .m_out_a     (m_out_a),
        .m_out_b     (m_out_b),
        .m_out_tx    (m_out_tx),
        .m_out_c     (m_out_c),
        .m_out_d     (m_out_d),
        .m_out_ty    (m_out_ty),
        .m_saturated (m_saturated)
    );

endmodule

// File: hdl/amc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amc_checker
// Port-level checks for the matrix composer, bound to the top level.
// ----------------------------------------------------------------------------
`include "affine_matrix_composer_macros.svh"

module amc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_out_a,
    input logic signed [31:0] m_out_tx,
    input logic signed [31:0] m_out_d,
    input logic               m_saturated
);

    // reset leaves the block empty and ready
    `AMC_ASSERT_NEXT_ALWAYS(a_reset_idle, aclk, !aresetn, !m_valid && s_ready)

    // one command at a time: busy right after a beat is taken
    `AMC_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

    // a waiting result holds
    `AMC_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_out_a) && $stable(m_out_tx) && $stable(m_out_d) && $stable(m_saturated))

endmodule

bind affine_matrix_composer amc_checker u_amc_checker (.*);
